// ----- src/nnd_pkg.sv -----
// Shared types and constants for the nearest-neighbor downscaler.
`default_nettype none

package nnd_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int CHAN_W       = 3;
    localparam int LOD_W        = 4;
    localparam int REM_W        = LOD_W + 1;
    localparam int MAX_CHANNELS = 4;

    typedef logic [PIX_W-1:0]      pix_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SRC_WIDTH     = 2'd0,
        REG_SRC_HEIGHT    = 2'd1,
        REG_CHANNEL_COUNT = 2'd2,
        REG_LOD_DIVISOR   = 2'd3
    } cfg_index_t;

    // Per-pixel decision from the position tracker.
    typedef struct packed {
        logic emit;
        logic last;
    } sel_t;

endpackage

`default_nettype wire

// ----- src/nnd_if.sv -----
// Handshake interfaces for pixel input, pixel output and register writes.
`default_nettype none

interface nnd_pix_in_if
    import nnd_pkg::*;
();
    logic valid;
    logic ready;
    pix_t pixel_c0;
    pix_t pixel_c1;
    pix_t pixel_c2;
    pix_t pixel_c3;

    modport source (output valid, pixel_c0, pixel_c1, pixel_c2, pixel_c3, input ready);
    modport sink   (input valid, pixel_c0, pixel_c1, pixel_c2, pixel_c3, output ready);
endinterface

interface nnd_pix_out_if
    import nnd_pkg::*;
();
    logic valid;
    logic ready;
    pix_t out_c0;
    pix_t out_c1;
    pix_t out_c2;
    pix_t out_c3;
    logic frame_last;

    modport source (output valid, out_c0, out_c1, out_c2, out_c3, frame_last, input ready);
    modport sink   (input valid, out_c0, out_c1, out_c2, out_c3, frame_last, output ready);
endinterface

interface nnd_cfg_if
    import nnd_pkg::*;
();
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/nearest_neighbor_downscaler.sv -----
// Top level: nearest-neighbor image downscaler with register port.
//
//  channel   | dir | payload                                  | handshake
//  ----------+-----+------------------------------------------+----------
//  pix_in    | in  | pixel_c0..pixel_c3 (8 b each)             | valid/ready
//  pix_out   | out | out_c0..out_c3 (8 b each), frame_last     | valid/ready
//  cfg       | in  | index (2 b), data (13 b)                  | valid/ready
//
// One source pixel per clock while no resize is in progress and the output
// register is free or draining: a request is decided by the position tracker
// and registered in the output register; a full output register that is being
// drained does not stall the input. A register write restarts the frame and
// starts the two bit-serial size dividers; pix_in.ready stays low until the
// reduced sizes are loaded. cfg.ready is always high.
// Reset: 1x1 source, four channels, divisor one, empty output register.
`default_nettype none

module nearest_neighbor_downscaler
    import nnd_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  wire logic clk,
    input  wire logic rst_n,
    nnd_pix_in_if.sink    pix_in,
    nnd_pix_out_if.source pix_out,
    nnd_cfg_if.sink       cfg
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    // configuration registers, raw as written
    cfg_data_t         src_width_reg;
    cfg_data_t         src_height_reg;
    logic [CHAN_W-1:0] channel_count_reg;
    logic [LOD_W-1:0]  lod_divisor_reg;
    logic              start_reg;

    logic              cfg_write;
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [DIM_W-1:0]  nw;
    logic [DIM_W-1:0]  nh;
    logic [CHAN_W-1:0] ch_eff;
    logic              w_busy, h_busy;
    logic              w_done, h_done;
    logic              sizing;
    logic              accept;
    sel_t              sel;

    // output register
    logic              out_valid_reg, out_valid_next;
    pix_t              out_c0_reg, out_c1_reg, out_c2_reg, out_c3_reg;
    logic              last_reg;

    // ---------------- register port ----------------
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg     <= CFG_DATA_W'(1);
            src_height_reg    <= CFG_DATA_W'(1);
            channel_count_reg <= CHAN_W'(MAX_CHANNELS);
            lod_divisor_reg   <= LOD_W'(1);
            start_reg         <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_write)
            begin
                case (cfg.index)
                    REG_SRC_WIDTH:
                    begin
                        src_width_reg <= cfg.data;
                        start_reg     <= 1'b1;
                    end
                    REG_SRC_HEIGHT:
                    begin
                        src_height_reg <= cfg.data;
                        start_reg      <= 1'b1;
                    end
                    REG_CHANNEL_COUNT:
                    begin
                        channel_count_reg <= cfg.data[CHAN_W-1:0];
                        start_reg         <= 1'b1;
                    end
                    REG_LOD_DIVISOR:
                    begin
                        lod_divisor_reg <= cfg.data[LOD_W-1:0];
                        start_reg       <= 1'b1;
                    end
                    default:
                    begin
                        start_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    // clamp sizes: zero acts as one, oversize saturates
    always_comb
    begin
        if (src_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (32'(src_width_reg) > MAX_DIM)
            w_eff = DIM_W'(MAX_DIM);
        else
            w_eff = DIM_W'(src_width_reg);

        if (src_height_reg == '0)
            h_eff = DIM_W'(1);
        else if (32'(src_height_reg) > MAX_DIM)
            h_eff = DIM_W'(MAX_DIM);
        else
            h_eff = DIM_W'(src_height_reg);

        if (channel_count_reg == '0)
            ch_eff = CHAN_W'(1);
        else if (channel_count_reg > CHAN_W'(MAX_CHANNELS))
            ch_eff = CHAN_W'(MAX_CHANNELS);
        else
            ch_eff = channel_count_reg;
    end

    // ---------------- reduced sizes ----------------
    nnd_div #(.DIM_W(DIM_W)) u_div_w (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (w_eff),
        .divisor  (lod_divisor_reg),
        .busy     (w_busy),
        .done     (w_done),
        .reduced  (nw)
    );

    nnd_div #(.DIM_W(DIM_W)) u_div_h (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (h_eff),
        .divisor  (lod_divisor_reg),
        .busy     (h_busy),
        .done     (h_done),
        .reduced  (nh)
    );

    // hold off requests until the new sizes are in and the frame restarted
    assign sizing = start_reg || w_busy || h_busy || w_done || h_done;

    // ---------------- position tracker ----------------
    assign pix_in.ready = !sizing && (!out_valid_reg || pix_out.ready);
    assign accept       = pix_in.valid && pix_in.ready;

    nnd_tracker #(.MAX_DIM(MAX_DIM)) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .restart (w_done),
        .w       (w_eff),
        .h       (h_eff),
        .nw      (nw),
        .nh      (nh),
        .sel     (sel)
    );

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = sel.emit;
        else if (pix_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // load payload on a selected pixel; drop unused channels to zero
    always_ff @(posedge clk)
    begin
        if (accept && sel.emit)
        begin
            out_c0_reg <= pix_in.pixel_c0;
            out_c1_reg <= (ch_eff > CHAN_W'(1)) ? pix_in.pixel_c1 : '0;
            out_c2_reg <= (ch_eff > CHAN_W'(2)) ? pix_in.pixel_c2 : '0;
            out_c3_reg <= (ch_eff > CHAN_W'(3)) ? pix_in.pixel_c3 : '0;
            last_reg   <= sel.last;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.out_c0     = out_c0_reg;
    assign pix_out.out_c1     = out_c1_reg;
    assign pix_out.out_c2     = out_c2_reg;
    assign pix_out.out_c3     = out_c3_reg;
    assign pix_out.frame_last = last_reg;

    // ---------------- checks ----------------
    a_no_accept_while_sizing: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(w_busy || h_busy || w_done || start_reg))
        else $error("request accepted while sizes are being computed");

    a_dividers_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        w_done == h_done)
        else $error("width and height dividers out of step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pix_out.ready) |-> !accept)
        else $error("pending result overwritten");

    a_restart_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(start_reg) |=> w_busy)
        else $error("divider did not start after register write");

endmodule

`default_nettype wire

// ----- src/nnd_div.sv -----
// Bit-serial restoring divider: reduced size = max(1, dim / lod).
`default_nettype none

module nnd_div
    import nnd_pkg::*;
#(
    parameter int DIM_W = 13
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIM_W-1:0] dividend,
    input  wire logic [LOD_W-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIM_W-1:0]      reduced
);

    localparam int CNT_W = $clog2(DIM_W + 1);

    logic [DIM_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [LOD_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [REM_W-1:0] trial;
    logic [DIM_W:0]   shifted;
    logic             qbit;

    always_comb
    begin
        trial    = {rem_reg[REM_W-2:0], quo_reg[DIM_W-1]};
        qbit     = (trial >= REM_W'(dsr_reg));
        shifted  = {quo_reg, qbit};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            // a zero divisor acts as one
            dsr_next = (divisor == '0) ? LOD_W'(1) : divisor;
            cnt_next = CNT_W'(DIM_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next  = shifted[DIM_W-1:0];
            rem_next  = qbit ? (trial - REM_W'(dsr_reg)) : trial;
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= DIM_W'(1);
            rem_reg  <= '0;
            dsr_reg  <= LOD_W'(1);
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign busy    = (cnt_reg != '0);
    assign done    = done_reg;
    assign reduced = (quo_reg == '0) ? DIM_W'(1) : quo_reg;

endmodule

`default_nettype wire

// ----- src/nnd_tracker.sv -----
// Column and row selection by running products, one source pixel per step.
`default_nettype none

module nnd_tracker
    import nnd_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              step,
    input  wire logic                              restart,
    input  wire logic [$clog2(MAX_DIM + 1)-1:0]    w,
    input  wire logic [$clog2(MAX_DIM + 1)-1:0]    h,
    input  wire logic [$clog2(MAX_DIM + 1)-1:0]    nw,
    input  wire logic [$clog2(MAX_DIM + 1)-1:0]    nh,
    output sel_t                                   sel
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int PROD_W = $clog2(MAX_DIM * MAX_DIM + 1);

    logic [CNT_W-1:0]  src_col_reg, src_col_next;
    logic [CNT_W-1:0]  src_row_reg, src_row_next;
    logic [CNT_W-1:0]  dst_col_reg, dst_col_next;
    logic [CNT_W-1:0]  dst_row_reg, dst_row_next;
    logic [PROD_W-1:0] col_tgt_reg, col_tgt_next;
    logic [PROD_W-1:0] col_bnd_reg, col_bnd_next;
    logic [PROD_W-1:0] row_tgt_reg, row_tgt_next;
    logic [PROD_W-1:0] row_bnd_reg, row_bnd_next;
    logic              row_sel;
    logic              col_sel;
    logic              col_end;
    logic              row_end;

    assign row_sel = (row_tgt_reg < row_bnd_reg);
    assign col_sel = (col_tgt_reg < col_bnd_reg);
    assign col_end = ((DIM_W'(src_col_reg) + DIM_W'(1)) >= w);
    assign row_end = ((DIM_W'(src_row_reg) + DIM_W'(1)) >= h);

    assign sel.emit = row_sel && col_sel;
    assign sel.last = (DIM_W'(dst_col_reg) == (nw - DIM_W'(1)))
                   && (DIM_W'(dst_row_reg) == (nh - DIM_W'(1)));

    always_comb
    begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        dst_col_next = dst_col_reg;
        dst_row_next = dst_row_reg;
        col_tgt_next = col_tgt_reg;
        col_bnd_next = col_bnd_reg;
        row_tgt_next = row_tgt_reg;
        row_bnd_next = row_bnd_reg;
        if (restart || (step && col_end && row_end))
        begin
            src_col_next = '0;
            src_row_next = '0;
            dst_col_next = '0;
            dst_row_next = '0;
            col_tgt_next = '0;
            col_bnd_next = PROD_W'(nw);
            row_tgt_next = '0;
            row_bnd_next = PROD_W'(nh);
        end
        else if (step)
        begin
            if (col_end)
            begin
                // wrap to the next source row
                src_col_next = '0;
                dst_col_next = '0;
                col_tgt_next = '0;
                col_bnd_next = PROD_W'(nw);
                src_row_next = src_row_reg + CNT_W'(1);
                row_bnd_next = row_bnd_reg + PROD_W'(nh);
                if (row_sel)
                begin
                    dst_row_next = dst_row_reg + CNT_W'(1);
                    row_tgt_next = row_tgt_reg + PROD_W'(h);
                end
            end
            else
            begin
                src_col_next = src_col_reg + CNT_W'(1);
                col_bnd_next = col_bnd_reg + PROD_W'(nw);
                if (col_sel)
                begin
                    dst_col_next = dst_col_reg + CNT_W'(1);
                    col_tgt_next = col_tgt_reg + PROD_W'(w);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            dst_col_reg <= '0;
            dst_row_reg <= '0;
            col_tgt_reg <= '0;
            col_bnd_reg <= PROD_W'(1);
            row_tgt_reg <= '0;
            row_bnd_reg <= PROD_W'(1);
        end
        else
        begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            dst_col_reg <= dst_col_next;
            dst_row_reg <= dst_row_next;
            col_tgt_reg <= col_tgt_next;
            col_bnd_reg <= col_bnd_next;
            row_tgt_reg <= row_tgt_next;
            row_bnd_reg <= row_bnd_next;
        end
    end

    // the destination column count never runs past the reduced width
    a_dst_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !restart) |-> (DIM_W'(dst_col_reg) <= nw))
        else $error("destination column beyond reduced width");

endmodule

`default_nettype wire
